// ===== rtl/itpb_pkg.sv =====
`default_nettype none

package itpb_pkg;

    // Sizing
    localparam int unsigned PAYLOAD_MAX_DEF = 128;
    localparam int unsigned HDR_WORDS       = 10;
    localparam int unsigned LEN_W           = 8;   // payload length, up to 255 bytes
    localparam int unsigned SUM_W           = 24;  // running payload sum, no wrap below 216 bytes

    // Fixed header contents
    localparam logic [7:0]  IP_VER_IHL    = 8'h45;
    localparam logic [15:0] IP_FLAGS_DF   = 16'h4000;
    localparam logic [7:0]  IP_PROTO_TCP  = 8'd6;
    localparam logic [7:0]  TCP_OFFSET    = 8'h50;
    localparam logic [15:0] TCP_WINDOW    = 16'hFFFF;
    localparam logic [15:0] IP_HDR_BYTES  = 16'd40;   // IPv4 + TCP headers
    localparam logic [15:0] TCP_HDR_BYTES = 16'd20;

    // Configuration register indexes
    localparam logic [2:0] CFG_SRC_ADDR = 3'd0;
    localparam logic [2:0] CFG_DST_ADDR = 3'd1;
    localparam logic [2:0] CFG_SRC_PORT = 3'd2;
    localparam logic [2:0] CFG_DST_PORT = 3'd3;
    localparam logic [2:0] CFG_POISON   = 3'd4;

    // Item actions
    localparam logic ACT_APPEND = 1'b0;
    localparam logic ACT_SEND   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CSUM,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic        action;
        logic [7:0]  payload_byte;
        logic [31:0] seq_number;
        logic [31:0] ack_number;
        logic [15:0] ident;
        logic [7:0]  hop_limit;
        logic [7:0]  flag_bits;
        logic        corrupt_checksum;
    } t_in_item;

    typedef struct packed {
        logic [31:0] packet_word;
        logic [2:0]  valid_bytes;
        logic        truncated;
        logic        last_word;
    } t_out_item;

    // Per-segment header snapshot shared by the emitter and the checksum unit
    typedef struct packed {
        logic [31:0]      source_address;
        logic [31:0]      dest_address;
        logic [15:0]      source_port;
        logic [15:0]      dest_port;
        logic [31:0]      seq_number;
        logic [31:0]      ack_number;
        logic [15:0]      ident;
        logic [7:0]       hop_limit;
        logic [7:0]       flag_bits;
        logic [LEN_W-1:0] payload_len;
        logic [SUM_W-1:0] payload_sum;
    } t_hdr;

endpackage

`default_nettype wire

// ===== rtl/itpb_csum.sv =====
`default_nettype none

// Sequential checksum unit: one 16-bit term per cycle into two accumulators,
// then two end-around-carry folds; o_done pulses when the second fold is done.
module itpb_csum (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire itpb_pkg::t_hdr i_hdr,
    output logic                o_done,
    output logic [15:0]         o_ip_csum,
    output logic [15:0]         o_tcp_csum
);

    localparam int unsigned ACC_W = itpb_pkg::SUM_W + 1;

    // Term sequence
    localparam logic [4:0] STEP_VER     = 5'd0;
    localparam logic [4:0] STEP_TOTAL   = 5'd1;
    localparam logic [4:0] STEP_IDENT   = 5'd2;
    localparam logic [4:0] STEP_FRAG    = 5'd3;
    localparam logic [4:0] STEP_TTL     = 5'd4;
    localparam logic [4:0] STEP_SRC_HI  = 5'd5;
    localparam logic [4:0] STEP_SRC_LO  = 5'd6;
    localparam logic [4:0] STEP_DST_HI  = 5'd7;
    localparam logic [4:0] STEP_DST_LO  = 5'd8;
    localparam logic [4:0] STEP_TCP_LEN = 5'd9;
    localparam logic [4:0] STEP_PORTS_S = 5'd10;
    localparam logic [4:0] STEP_PORTS_D = 5'd11;
    localparam logic [4:0] STEP_SEQ_HI  = 5'd12;
    localparam logic [4:0] STEP_SEQ_LO  = 5'd13;
    localparam logic [4:0] STEP_ACK_HI  = 5'd14;
    localparam logic [4:0] STEP_ACK_LO  = 5'd15;
    localparam logic [4:0] STEP_FLAGS   = 5'd16;
    localparam logic [4:0] STEP_WINDOW  = 5'd17;
    localparam logic [4:0] STEP_PSUM    = 5'd18;
    localparam logic [4:0] STEP_FOLD_A  = 5'd19;
    localparam logic [4:0] STEP_FOLD_B  = 5'd20;

    logic             r_run;
    logic             r_done;
    logic [4:0]       r_step;
    logic [ACC_W-1:0] r_ip_acc;
    logic [ACC_W-1:0] r_tcp_acc;

    logic [ACC_W-1:0] term;
    logic             ip_en;
    logic             tcp_en;

    function automatic logic [ACC_W-1:0] fold(input logic [ACC_W-1:0] x);
        return ACC_W'(x[15:0]) + ACC_W'(x[ACC_W-1:16]);
    endfunction

    // Term select
    always_comb begin
        term   = '0;
        ip_en  = 1'b0;
        tcp_en = 1'b0;
        unique case (r_step)
            STEP_VER: begin
                term  = ACC_W'({itpb_pkg::IP_VER_IHL, 8'h00});
                ip_en = 1'b1;
            end
            STEP_TOTAL: begin
                term  = ACC_W'(itpb_pkg::IP_HDR_BYTES + 16'(i_hdr.payload_len));
                ip_en = 1'b1;
            end
            STEP_IDENT: begin
                term  = ACC_W'(i_hdr.ident);
                ip_en = 1'b1;
            end
            STEP_FRAG: begin
                term  = ACC_W'(itpb_pkg::IP_FLAGS_DF);
                ip_en = 1'b1;
            end
            STEP_TTL: begin
                term  = ACC_W'({i_hdr.hop_limit, itpb_pkg::IP_PROTO_TCP});
                ip_en = 1'b1;
            end
            STEP_SRC_HI: begin
                term   = ACC_W'(i_hdr.source_address[31:16]);
                ip_en  = 1'b1;
                tcp_en = 1'b1;
            end
            STEP_SRC_LO: begin
                term   = ACC_W'(i_hdr.source_address[15:0]);
                ip_en  = 1'b1;
                tcp_en = 1'b1;
            end
            STEP_DST_HI: begin
                term   = ACC_W'(i_hdr.dest_address[31:16]);
                ip_en  = 1'b1;
                tcp_en = 1'b1;
            end
            STEP_DST_LO: begin
                term   = ACC_W'(i_hdr.dest_address[15:0]);
                ip_en  = 1'b1;
                tcp_en = 1'b1;
            end
            STEP_TCP_LEN: begin
                // pseudo-header protocol plus TCP length
                term   = ACC_W'(16'(itpb_pkg::IP_PROTO_TCP) + itpb_pkg::TCP_HDR_BYTES
                              + 16'(i_hdr.payload_len));
                tcp_en = 1'b1;
            end
            STEP_PORTS_S: begin
                term   = ACC_W'(i_hdr.source_port);
                tcp_en = 1'b1;
            end
            STEP_PORTS_D: begin
                term   = ACC_W'(i_hdr.dest_port);
                tcp_en = 1'b1;
            end
            STEP_SEQ_HI: begin
                term   = ACC_W'(i_hdr.seq_number[31:16]);
                tcp_en = 1'b1;
            end
            STEP_SEQ_LO: begin
                term   = ACC_W'(i_hdr.seq_number[15:0]);
                tcp_en = 1'b1;
            end
            STEP_ACK_HI: begin
                term   = ACC_W'(i_hdr.ack_number[31:16]);
                tcp_en = 1'b1;
            end
            STEP_ACK_LO: begin
                term   = ACC_W'(i_hdr.ack_number[15:0]);
                tcp_en = 1'b1;
            end
            STEP_FLAGS: begin
                term   = ACC_W'({itpb_pkg::TCP_OFFSET, i_hdr.flag_bits});
                tcp_en = 1'b1;
            end
            STEP_WINDOW: begin
                term   = ACC_W'(itpb_pkg::TCP_WINDOW);
                tcp_en = 1'b1;
            end
            STEP_PSUM: begin
                term   = ACC_W'(i_hdr.payload_sum);
                tcp_en = 1'b1;
            end
            default: begin
                term = '0;
            end
        endcase
    end

    // Sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run  <= 1'b1;
                r_step <= '0;
            end else if (r_run) begin
                r_step <= r_step + 5'd1;
                if (r_step == STEP_FOLD_B) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Accumulators
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ip_acc  <= '0;
            r_tcp_acc <= '0;
        end else if (r_run) begin
            if (r_step == STEP_FOLD_A || r_step == STEP_FOLD_B) begin
                r_ip_acc  <= fold(r_ip_acc);
                r_tcp_acc <= fold(r_tcp_acc);
            end else begin
                if (ip_en) begin
                    r_ip_acc <= r_ip_acc + term;
                end
                if (tcp_en) begin
                    r_tcp_acc <= r_tcp_acc + term;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_ip_csum  = ~r_ip_acc[15:0];
    assign o_tcp_csum = ~r_tcp_acc[15:0];

endmodule

`default_nettype wire

// ===== rtl/ipv4_tcp_packet_builder.sv =====
`default_nettype none

// Channel   | Ports                                  | Handshake
// ----------+----------------------------------------+-------------------------------
// item in   | start, busy, i_item                    | taken when start && !busy
// word out  | o_valid, o_result                      | one cycle per word, no stall
// config    | i_cfg_wr, i_cfg_index, i_cfg_data      | written when i_cfg_wr is high
//
// Appends are accepted back to back, one per cycle while busy is low.
// A send holds busy while the checksum unit sequences its terms (one term per
// cycle), then while the 10 + ceil(len/4) words go out, one per cycle, set by
// the single read port of the payload memory. busy drops in the cycle that
// shows the last word. Reset is synchronous and clears the byte count, sum,
// overflow flag, configuration registers, state and word counter; the payload
// memory is not cleared. The receiver cannot stall the word stream.
module ipv4_tcp_packet_builder #(
    parameter int unsigned PAYLOAD_MAX = itpb_pkg::PAYLOAD_MAX_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire itpb_pkg::t_in_item  i_item,
    output logic                     o_valid,
    output itpb_pkg::t_out_item      o_result,
    input  wire logic                i_cfg_wr,
    input  wire logic [2:0]          i_cfg_index,
    input  wire logic [31:0]         i_cfg_data
);

    localparam int unsigned CNT_W     = $clog2(PAYLOAD_MAX + 1);
    localparam int unsigned MEM_DEPTH = (PAYLOAD_MAX + 3) / 4;
    localparam int unsigned ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int unsigned NWORDS    = itpb_pkg::HDR_WORDS + MEM_DEPTH;
    localparam int unsigned WCNT_W    = $clog2(NWORDS);

    // Header word positions
    localparam logic [WCNT_W-1:0] W_IP_VER    = WCNT_W'(0);
    localparam logic [WCNT_W-1:0] W_IP_FRAG   = WCNT_W'(1);
    localparam logic [WCNT_W-1:0] W_IP_CSUM   = WCNT_W'(2);
    localparam logic [WCNT_W-1:0] W_IP_SRC    = WCNT_W'(3);
    localparam logic [WCNT_W-1:0] W_IP_DST    = WCNT_W'(4);
    localparam logic [WCNT_W-1:0] W_TCP_PORTS = WCNT_W'(5);
    localparam logic [WCNT_W-1:0] W_TCP_SEQ   = WCNT_W'(6);
    localparam logic [WCNT_W-1:0] W_TCP_ACK   = WCNT_W'(7);
    localparam logic [WCNT_W-1:0] W_TCP_FLAGS = WCNT_W'(8);
    localparam logic [WCNT_W-1:0] W_TCP_CSUM  = WCNT_W'(9);

    // Configuration registers
    logic [31:0] r_src_addr;
    logic [31:0] r_dst_addr;
    logic [15:0] r_src_port;
    logic [15:0] r_dst_port;
    logic [15:0] r_poison;

    // Payload accumulation state
    logic [CNT_W-1:0]          r_count;
    logic [itpb_pkg::SUM_W-1:0] r_sum;
    logic                      r_ovf;
    logic [31:0]               r_mem [MEM_DEPTH];
    logic [31:0]               r_rd;

    // Send state
    itpb_pkg::t_state    r_state;
    itpb_pkg::t_state    n_state;
    itpb_pkg::t_hdr      r_hdr;
    logic                r_corrupt;
    logic                r_trunc;
    logic [WCNT_W-1:0]   r_wcnt;
    logic                r_valid;
    itpb_pkg::t_out_item r_result;

    logic                accept;
    logic                is_append;
    logic                is_send;
    logic                room;
    logic                csum_start;
    logic                csum_done;
    logic [15:0]         ip_csum;
    logic [15:0]         tcp_csum;
    logic [15:0]         tcp_csum_out;
    logic [ADDR_W-1:0]   wr_addr;
    logic [4:0]          wr_shift;
    logic [ADDR_W-1:0]   rd_addr;
    logic [WCNT_W-1:0]   last_idx;
    logic [2:0]          rem;
    logic                is_last;
    logic [31:0]         pay_word;
    logic [31:0]         word;
    logic [15:0]         total_len;

    assign busy      = (r_state != itpb_pkg::ST_IDLE);
    assign accept    = start && !busy;
    assign is_append = accept && (i_item.action == itpb_pkg::ACT_APPEND);
    assign is_send   = accept && (i_item.action == itpb_pkg::ACT_SEND);
    assign room      = (r_count < CNT_W'(PAYLOAD_MAX));

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_addr <= '0;
            r_dst_addr <= '0;
            r_src_port <= '0;
            r_dst_port <= '0;
            r_poison   <= '0;
        end else if (i_cfg_wr) begin
            unique case (i_cfg_index)
                itpb_pkg::CFG_SRC_ADDR: r_src_addr <= i_cfg_data;
                itpb_pkg::CFG_DST_ADDR: r_dst_addr <= i_cfg_data;
                itpb_pkg::CFG_SRC_PORT: r_src_port <= i_cfg_data[15:0];
                itpb_pkg::CFG_DST_PORT: r_dst_port <= i_cfg_data[15:0];
                itpb_pkg::CFG_POISON:   r_poison   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Byte count, running sum, overflow; cleared when a send is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_ovf   <= 1'b0;
        end else if (is_append) begin
            if (room) begin
                r_count <= r_count + CNT_W'(1);
                r_sum   <= r_sum + (r_count[0] ? itpb_pkg::SUM_W'(i_item.payload_byte)
                                               : itpb_pkg::SUM_W'({i_item.payload_byte, 8'h00}));
            end else begin
                r_ovf <= 1'b1;
            end
        end else if (is_send) begin
            r_count <= '0;
            r_sum   <= '0;
            r_ovf   <= 1'b0;
        end
    end

    // Payload memory: byte-lane write, registered word read
    assign wr_addr  = ADDR_W'(r_count >> 2);
    assign wr_shift = {~r_count[1:0], 3'b000};
    assign rd_addr  = ADDR_W'(r_wcnt - WCNT_W'(itpb_pkg::HDR_WORDS - 1));

    always_ff @(posedge i_clk) begin
        if (is_append && room) begin
            r_mem[wr_addr][wr_shift +: 8] <= i_item.payload_byte;
        end
        r_rd <= r_mem[rd_addr];
    end

    // Header snapshot on send
    always_ff @(posedge i_clk) begin
        if (is_send) begin
            r_hdr.source_address <= r_src_addr;
            r_hdr.dest_address   <= r_dst_addr;
            r_hdr.source_port    <= r_src_port;
            r_hdr.dest_port      <= r_dst_port;
            r_hdr.seq_number     <= i_item.seq_number;
            r_hdr.ack_number     <= i_item.ack_number;
            r_hdr.ident          <= i_item.ident;
            r_hdr.hop_limit      <= i_item.hop_limit;
            r_hdr.flag_bits      <= i_item.flag_bits;
            r_hdr.payload_len    <= itpb_pkg::LEN_W'(r_count);
            r_hdr.payload_sum    <= r_sum;
            r_corrupt            <= i_item.corrupt_checksum;
            r_trunc              <= r_ovf;
        end
    end

    itpb_csum u_csum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (csum_start),
        .i_hdr      (r_hdr),
        .o_done     (csum_done),
        .o_ip_csum  (ip_csum),
        .o_tcp_csum (tcp_csum)
    );

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= itpb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state    = r_state;
        csum_start = 1'b0;
        unique case (r_state)
            itpb_pkg::ST_IDLE: begin
                if (is_send) begin
                    n_state    = itpb_pkg::ST_CSUM;
                    csum_start = 1'b1;
                end
            end
            itpb_pkg::ST_CSUM: begin
                if (csum_done) begin
                    n_state = itpb_pkg::ST_EMIT;
                end
            end
            itpb_pkg::ST_EMIT: begin
                if (is_last) begin
                    n_state = itpb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = itpb_pkg::ST_IDLE;
            end
        endcase
    end

    // Packet geometry
    assign total_len = itpb_pkg::IP_HDR_BYTES + 16'(r_hdr.payload_len);
    assign last_idx  = WCNT_W'(itpb_pkg::HDR_WORDS - 1)
                     + WCNT_W'((r_hdr.payload_len + itpb_pkg::LEN_W'(3)) >> 2);
    assign rem       = (r_hdr.payload_len == '0) ? 3'd4
                     : {1'b0, 2'(r_hdr.payload_len - itpb_pkg::LEN_W'(1))} + 3'd1;
    assign is_last   = (r_wcnt == last_idx);
    assign tcp_csum_out = r_corrupt ? r_poison : tcp_csum;

    // Payload word with bytes past the end zeroed
    always_comb begin
        pay_word = r_rd;
        for (int l = 0; l < 4; l++) begin
            if (is_last && (3'(l) >= rem)) begin
                pay_word[8 * (3 - l) +: 8] = 8'h00;
            end
        end
    end

    // Word select
    always_comb begin
        case (r_wcnt)
            W_IP_VER:    word = {itpb_pkg::IP_VER_IHL, 8'h00, total_len};
            W_IP_FRAG:   word = {r_hdr.ident, itpb_pkg::IP_FLAGS_DF};
            W_IP_CSUM:   word = {r_hdr.hop_limit, itpb_pkg::IP_PROTO_TCP, ip_csum};
            W_IP_SRC:    word = r_hdr.source_address;
            W_IP_DST:    word = r_hdr.dest_address;
            W_TCP_PORTS: word = {r_hdr.source_port, r_hdr.dest_port};
            W_TCP_SEQ:   word = r_hdr.seq_number;
            W_TCP_ACK:   word = r_hdr.ack_number;
            W_TCP_FLAGS: word = {itpb_pkg::TCP_OFFSET, r_hdr.flag_bits, itpb_pkg::TCP_WINDOW};
            W_TCP_CSUM:  word = {tcp_csum_out, 16'h0000};
            default:     word = pay_word;
        endcase
    end

    // Word counter and output strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_wcnt  <= '0;
        end else begin
            r_valid <= (r_state == itpb_pkg::ST_EMIT);
            if (r_state == itpb_pkg::ST_EMIT) begin
                r_wcnt <= r_wcnt + WCNT_W'(1);
            end else begin
                r_wcnt <= '0;
            end
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (r_state == itpb_pkg::ST_EMIT) begin
            r_result.packet_word <= word;
            r_result.valid_bytes <= is_last ? rem : 3'd4;
            r_result.truncated   <= r_trunc;
            r_result.last_word   <= is_last;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import itpb_pkg::*;

    localparam int unsigned PAYLOAD_CAP    = PAYLOAD_MAX_DEF;
    localparam int unsigned RANDOM_ITEMS   = 90;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned SETTLE_CYCLES  = 4;
    localparam int unsigned DRAIN_CYCLES   = 100;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_in_item   i_item;
    logic       o_valid;
    t_out_item  o_result;
    logic       i_cfg_wr;
    logic [2:0] i_cfg_index;
    logic [31:0] i_cfg_data;

    ipv4_tcp_packet_builder #(
        .PAYLOAD_MAX(PAYLOAD_CAP)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .i_cfg_wr    (i_cfg_wr),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Connection registers as the block should hold them
    logic [31:0] conn_src_addr;
    logic [31:0] conn_dst_addr;
    logic [15:0] conn_src_port;
    logic [15:0] conn_dst_port;
    logic [15:0] conn_poison;

    // Payload buffer as the block should hold it
    logic [7:0]  pl_store [PAYLOAD_CAP];
    int unsigned pl_count;
    logic [31:0] pl_sum;
    logic        pl_over;

    t_out_item   pending_words [$];
    t_out_item   want_word;
    int unsigned fail_count;
    int unsigned stall_cycles;
    int unsigned items_sent;
    bit          burst_mode;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // End-around carry fold down to 16 bits
    function automatic logic [15:0] fold16(logic [31:0] s);
        while (s[31:16] != 16'd0) begin
            s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
        end
        return s[15:0];
    endfunction

    // Plain sum of the ten 16-bit words of a 20-byte header
    function automatic logic [31:0] sum_halfwords(logic [159:0] h);
        logic [31:0] s;
        s = '0;
        for (int i = 0; i < 10; i++) begin
            s += {16'd0, h[159 - 16*i -: 16]};
        end
        return s;
    endfunction

    // Expected word stream of one send; clears the buffer afterwards
    task automatic build_packet(input t_in_item it);
        logic [15:0]  total16;
        logic [15:0]  tcp_len16;
        logic [15:0]  tcp_csum;
        logic [31:0]  pseudo;
        logic [159:0] ip_hdr;
        logic [159:0] tcp_hdr;
        logic [7:0]   octet;
        t_out_item    w;
        int unsigned  total;
        int unsigned  nwords;
        int unsigned  pos;

        total16   = IP_HDR_BYTES + 16'(pl_count);
        tcp_len16 = TCP_HDR_BYTES + 16'(pl_count);

        ip_hdr = {IP_VER_IHL, 8'h00, total16, it.ident, IP_FLAGS_DF, it.hop_limit,
                  IP_PROTO_TCP, 16'h0000, conn_src_addr, conn_dst_addr};
        ip_hdr[79:64] = ~fold16(sum_halfwords(ip_hdr));

        tcp_hdr = {conn_src_port, conn_dst_port, it.seq_number, it.ack_number,
                   TCP_OFFSET, it.flag_bits, TCP_WINDOW, 16'h0000, 16'h0000};
        if (it.corrupt_checksum) begin
            tcp_csum = conn_poison;
        end else begin
            pseudo = {16'd0, conn_src_addr[31:16]} + {16'd0, conn_src_addr[15:0]}
                   + {16'd0, conn_dst_addr[31:16]} + {16'd0, conn_dst_addr[15:0]}
                   + 32'(IP_PROTO_TCP) + 32'(tcp_len16);
            pseudo = 32'(fold16(pseudo)) + 32'(fold16(sum_halfwords(tcp_hdr)))
                   + 32'(fold16(pl_sum));
            tcp_csum = ~fold16(pseudo);
        end
        tcp_hdr[31:16] = tcp_csum;

        total  = 32'(total16);
        nwords = (total + 3) / 4;
        for (int unsigned k = 0; k < nwords; k++) begin
            w.packet_word = '0;
            for (int unsigned j = 0; j < 4; j++) begin
                pos = 4*k + j;
                if (pos < 20)
                    octet = ip_hdr[159 - 8*pos -: 8];
                else if (pos < 40)
                    octet = tcp_hdr[159 - 8*(pos - 20) -: 8];
                else if (pos < total)
                    octet = pl_store[pos - 40];
                else
                    octet = 8'h00;
                w.packet_word = {w.packet_word[23:0], octet};
            end
            w.last_word   = (k + 1 == nwords);
            w.valid_bytes = w.last_word ? 3'(total - (nwords - 1) * 4) : 3'd4;
            w.truncated   = pl_over;
            pending_words.push_back(w);
        end

        pl_count = 0;
        pl_sum   = '0;
        pl_over  = 1'b0;
    endtask

    // Update the buffer on an append, or predict the packet on a send
    task automatic predict_item(input t_in_item it);
        if (it.action == ACT_APPEND) begin
            if (pl_count < PAYLOAD_CAP) begin
                pl_store[pl_count] = it.payload_byte;
                pl_sum += pl_count[0] ? {24'd0, it.payload_byte}
                                      : {16'd0, it.payload_byte, 8'h00};
                pl_count++;
            end else begin
                pl_over = 1'b1;
            end
        end else begin
            build_packet(it);
        end
    endtask

    task automatic apply_config(input logic [2:0] idx, input logic [31:0] data);
        case (idx)
            CFG_SRC_ADDR: conn_src_addr = data;
            CFG_DST_ADDR: conn_dst_addr = data;
            CFG_SRC_PORT: conn_src_port = data[15:0];
            CFG_DST_PORT: conn_dst_port = data[15:0];
            CFG_POISON:   conn_poison   = data[15:0];
            default: ;
        endcase
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_wr    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        apply_config(idx, data);
    endtask

    // All five registers, then a write to an unused index that must be ignored
    task automatic set_config(input logic [31:0] src, input logic [31:0] dst,
                              input logic [15:0] sport, input logic [15:0] dport,
                              input logic [15:0] poison);
        cfg_write(CFG_SRC_ADDR, src);
        cfg_write(CFG_DST_ADDR, dst);
        cfg_write(CFG_SRC_PORT, {$urandom} << 16 | 32'(sport));
        cfg_write(CFG_DST_PORT, {16'(32'($urandom)), dport});
        cfg_write(CFG_POISON,   {16'(32'($urandom)), poison});
        cfg_write(CFG_POISON + 3'($urandom_range(1, 3)), $urandom);
        i_cfg_wr <= 1'b0;
        @(posedge i_clk);
    endtask

    // Present one item and hold it until it is taken
    task automatic send_item(input t_in_item it);
        start  <= 1'b1;
        i_item <= it;
        do begin
            @(posedge i_clk);
        end while (busy);
        predict_item(it);
        items_sent++;
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic idle_gap();
        int unsigned n;
        n = pick_gap();
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Quiet the sender and let every expected word drain out
    task automatic settle();
        start <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_word32();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return 32'h0000_0000;
        if (r == 1) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    function automatic t_in_item rand_item(input logic act);
        t_in_item it;
        it.action           = act;
        it.payload_byte     = 8'($urandom);
        it.seq_number       = rand_word32();
        it.ack_number       = rand_word32();
        it.ident            = 16'(rand_word32());
        it.hop_limit        = 8'($urandom);
        it.flag_bits        = 8'($urandom);
        it.corrupt_checksum = ($urandom_range(0, 3) == 0);
        return it;
    endfunction

    // n appends (fill < 0 gives random bytes), then the send word
    task automatic send_packet(input int unsigned n, input int fill,
                               input t_in_item send_it);
        t_in_item it;
        for (int unsigned i = 0; i < n; i++) begin
            it = rand_item(ACT_APPEND);
            if (fill >= 0) it.payload_byte = 8'(fill);
            send_item(it);
            idle_gap();
        end
        send_item(send_it);
        idle_gap();
    endtask

    // Result checker: every word against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_words.size() == 0) begin
                $error("unexpected word: packet_word %h", o_result.packet_word);
                fail_count++;
            end else begin
                want_word = pending_words.pop_front();
                if (o_result.packet_word !== want_word.packet_word) begin
                    $error("packet_word expected %h actual %h",
                           want_word.packet_word, o_result.packet_word);
                    fail_count++;
                end
                if (o_result.valid_bytes !== want_word.valid_bytes) begin
                    $error("valid_bytes expected %0d actual %0d",
                           want_word.valid_bytes, o_result.valid_bytes);
                    fail_count++;
                end
                if (o_result.truncated !== want_word.truncated) begin
                    $error("truncated expected %b actual %b",
                           want_word.truncated, o_result.truncated);
                    fail_count++;
                end
                if (o_result.last_word !== want_word.last_word) begin
                    $error("last_word expected %b actual %b",
                           want_word.last_word, o_result.last_word);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no traffic at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || i_cfg_wr) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Header built from the reset register values
    task automatic test_reset_config();
        t_in_item it;
        it        = '0;
        it.action = ACT_SEND;
        send_packet(0, 0, it);
        send_packet(1, 8'h00, it);
    endtask

    // Field extremes, odd and even lengths, poisoned checksum
    task automatic test_directed_packets();
        t_in_item it;
        settle();
        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        it                  = '1;
        it.corrupt_checksum = 1'b0;
        send_packet(0, 0, it);
        send_packet(1, 8'hFF, it);
        it.corrupt_checksum = 1'b1;
        send_packet(3, -1, it);
        it                  = '0;
        it.action           = ACT_SEND;
        send_packet(4, 8'h00, it);
        send_packet(5, -1, rand_item(ACT_SEND));
        settle();
        set_config(32'h0A00_0001, 32'hC0A8_0102, 16'h0050, 16'hC350, 16'h0000);
        it                  = rand_item(ACT_SEND);
        it.corrupt_checksum = 1'b1;
        send_packet(1, -1, it);
    endtask

    // Buffer filled past capacity, then a short packet after it
    task automatic test_buffer_full();
        settle();
        set_config($urandom, $urandom, 16'($urandom), 16'($urandom), 16'($urandom));
        burst_mode = 1'b1;
        send_packet(PAYLOAD_CAP + 2, -1, rand_item(ACT_SEND));
        burst_mode = 1'b0;
        // overflow flag must not survive the send
        send_packet(2, -1, rand_item(ACT_SEND));
    endtask

    // Random packets, mostly short, with periodic reconfiguration
    task automatic test_random_packets();
        int unsigned first_item;
        int unsigned pkt_num;
        int unsigned r;
        int unsigned n;
        first_item = items_sent;
        pkt_num    = 0;
        while (items_sent - first_item < RANDOM_ITEMS) begin
            if (pkt_num % 6 == 0) begin
                settle();
                set_config(rand_word32(), rand_word32(), 16'(rand_word32()),
                           16'(rand_word32()), 16'(rand_word32()));
                burst_mode = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < 75)
                n = $urandom_range(0, 8);
            else
                n = $urandom_range(9, 40);
            send_packet(n, -1, rand_item(ACT_SEND));
            pkt_num++;
        end
    endtask

    initial begin
        start         <= 1'b0;
        i_item        <= '0;
        i_cfg_wr      <= 1'b0;
        i_cfg_index   <= CFG_SRC_ADDR;
        i_cfg_data    <= '0;
        i_rst_n       <= 1'b0;
        conn_src_addr = '0;
        conn_dst_addr = '0;
        conn_src_port = '0;
        conn_dst_port = '0;
        conn_poison   = '0;
        pl_count      = 0;
        pl_sum        = '0;
        pl_over       = 1'b0;
        fail_count    = 0;
        stall_cycles  = 0;
        items_sent    = 0;
        burst_mode    = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_config();
        test_directed_packets();
        test_buffer_full();
        test_random_packets();

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_words.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
